>>> design/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants for the shelf rectangle allocator
// Item structures, status and opcode codes, atlas geometry constants.
// ----------------------------------------------------------------------------
package sra_pkg;

    // Width of every coordinate, dimension and side value.
    localparam int DIM_W = 15;

    // Atlas geometry.
    localparam int START_SIDE       = 1024;
    localparam int MAX_SIDE         = 16384;
    localparam int TILE_SIDE        = 32;
    localparam int DEF_MAX_SHELVES  = 64;

    // Opcodes of an input item.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_LIMIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic [DIM_W-1:0] pos_x;
        logic [DIM_W-1:0] pos_y;
        logic [DIM_W-1:0] side_now;
        logic [1:0]       status;
    } out_item_t;

    // One shelf as held in the shelf memory.
    typedef struct packed {
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] fill;
    } shelf_entry_t;

endpackage

>>> design/sra_shelf_ram.sv
// ----------------------------------------------------------------------------
// sra_shelf_ram: shelf table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sra_shelf_ram #(
    parameter int DEPTH = sra_pkg::DEF_MAX_SHELVES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output sra_pkg::shelf_entry_t rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  sra_pkg::shelf_entry_t wr_data
);

    sra_pkg::shelf_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/shelf_rectangle_allocator.sv
// ----------------------------------------------------------------------------
// shelf_rectangle_allocator: shelf packing allocator for a square atlas
// Places rectangles on shelves held in a synchronous shelf memory.
// ----------------------------------------------------------------------------
// One shelf is read per cycle. A pass over the shelves that finds no room
// hands over to S_DECIDE after the last shelf; a hit ends the pass at the
// matching shelf. Each doubling starts a new pass. The result strobe follows
// with busy already low, so the next item can be accepted at the edge ending
// it. The receiver cannot stall. Reset places the tile silently while busy.
// ----------------------------------------------------------------------------
module shelf_rectangle_allocator #(
    parameter int MAX_SHELVES = sra_pkg::DEF_MAX_SHELVES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sra_pkg::in_item_t  cmd,
    output logic               done,
    output sra_pkg::out_item_t result
);

    localparam int DW = sra_pkg::DIM_W;
    // Shelf memory address and shelf counter widths (the counter can hold
    // MAX_SHELVES itself).
    localparam int AW = $clog2(MAX_SHELVES);
    localparam int CW = $clog2(MAX_SHELVES + 1);

    localparam logic [DW-1:0] START_SIDE_C = DW'(sra_pkg::START_SIDE);
    localparam logic [DW-1:0] TILE_C       = DW'(sra_pkg::TILE_SIDE);
    localparam logic [DW:0]   MAX_SIDE_C   = (DW + 1)'(sra_pkg::MAX_SIDE);
    localparam logic [CW-1:0] MAX_COUNT_C  = CW'(MAX_SHELVES);

    // The controller walks the shelves in S_SCAN, reading one entry per cycle:
    // the read for the next shelf is issued while the data of the current one
    // is checked. S_DECIDE opens a new shelf, doubles the side or gives up.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t             state_reg,  state_next;
    logic [DW-1:0]      side_reg,   side_next;
    logic [DW-1:0]      used_reg,   used_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [AW-1:0]      idx_reg,    idx_next;
    logic [DW-1:0]      w_reg,      w_next;
    logic [DW-1:0]      h_reg,      h_next;
    logic               quiet_reg,  quiet_next;
    logic               done_reg,   done_next;
    sra_pkg::out_item_t result_reg, result_next;

    // Shelf memory ports.
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    sra_pkg::shelf_entry_t rd_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    sra_pkg::shelf_entry_t wr_data;

    // Search and placement terms.
    logic          hit;
    logic          last;
    logic          fits_new;
    logic [DW:0]   side_dbl;
    logic [CW-1:0] idx_inc;

    sra_shelf_ram #(
        .DEPTH (MAX_SHELVES),
        .AW    (AW)
    ) u_shelf_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // A shelf matches when its height equals the rectangle's and the
    // remaining width holds the rectangle. The sum is kept one bit wider
    // since a rectangle may be wider than the whole atlas.
    assign hit = (rd_data.height == h_reg)
              && ({1'b0, side_reg} >= ({1'b0, rd_data.fill} + {1'b0, w_reg}));

    assign idx_inc  = CW'(idx_reg) + CW'(1);
    assign last     = (idx_inc == count_reg);
    // used_reg never exceeds side_reg, so the difference cannot wrap.
    assign fits_new = (w_reg <= side_reg) && ((side_reg - used_reg) >= h_reg);
    assign side_dbl = {side_reg, 1'b0};

    always_comb
    begin
        state_next  = state_reg;
        side_next   = side_reg;
        used_next   = used_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        quiet_next  = quiet_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    quiet_next = 1'b0;
                    w_next     = cmd.rect_width;
                    h_next     = cmd.rect_height;
                    if (cmd.opcode == sra_pkg::OP_CLEAR)
                    begin
                        // Empty atlas, then place the default tile.
                        side_next  = START_SIDE_C;
                        used_next  = '0;
                        count_next = '0;
                        w_next     = TILE_C;
                        h_next     = TILE_C;
                        state_next = S_DECIDE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    // Extend the matching shelf; no read is issued in this
                    // cycle, so the write cannot race a read of the entry.
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg;
                    wr_data.fill = rd_data.fill + w_reg;
                    done_next    = !quiet_reg;
                    result_next  = '{pos_x: rd_data.fill, pos_y: rd_data.top,
                                     side_now: side_reg, status: sra_pkg::ST_PLACED};
                    state_next   = S_IDLE;
                end
                else if (last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end

            S_DECIDE:
            begin
                if (fits_new)
                begin
                    if (count_reg >= MAX_COUNT_C)
                    begin
                        done_next   = !quiet_reg;
                        result_next = '{pos_x: '0, pos_y: '0,
                                        side_now: side_reg, status: sra_pkg::ST_FULL};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = count_reg[AW-1:0];
                        wr_data     = '{top: used_reg, height: h_reg, fill: w_reg};
                        count_next  = count_reg + CW'(1);
                        used_next   = used_reg + h_reg;
                        done_next   = !quiet_reg;
                        result_next = '{pos_x: '0, pos_y: used_reg,
                                        side_now: side_reg, status: sra_pkg::ST_PLACED};
                        state_next  = S_IDLE;
                    end
                end
                else if (side_dbl > MAX_SIDE_C)
                begin
                    done_next   = !quiet_reg;
                    result_next = '{pos_x: '0, pos_y: '0,
                                    side_now: side_reg, status: sra_pkg::ST_LIMIT};
                    state_next  = S_IDLE;
                end
                else
                begin
                    // Double the side and search the shelves again; with none, decide again.
                    side_next = side_dbl[DW-1:0];
                    if (count_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Reset starts a silent clear: the default tile is placed exactly as a
    // clear item would place it, but no result is shown.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_DECIDE;
            side_reg   <= START_SIDE_C;
            used_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            w_reg      <= TILE_C;
            h_reg      <= TILE_C;
            quiet_reg  <= 1'b1;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            side_reg   <= side_next;
            used_reg   <= used_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            w_reg      <= w_next;
            h_reg      <= h_next;
            quiet_reg  <= quiet_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result only follows a cycle of work.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // The shelf counter never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT_C)
        else $error("shelf count beyond table size");

    // Used height stays inside the atlas.
    a_used_in_side: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= side_reg)
        else $error("used height beyond atlas side");

    // The side never passes its maximum.
    a_side_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, side_reg} <= MAX_SIDE_C)
        else $error("atlas side beyond maximum");

    // Reads and writes of the shelf memory never share a cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("shelf memory read and write in the same cycle");

endmodule
